/* rtl/bhts_pkg.sv */
// ----------------------------------------------------------------------------
// bhts_pkg
// Shared types and constants of the bilinear half texture sampler.
// ----------------------------------------------------------------------------
package bhts_pkg;

  // what the back end does with a queued transaction
  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ZERO   = 2'd2,
    KIND_DROP   = 2'd3
  } kind_t;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [16:0] Q15_ONE = 17'd32768;
  localparam logic [17:0] Q16_ONE = 18'd65536;

  // front-to-back queue, power of two
  localparam int QUEUE_DEPTH = 4;

endpackage

/* rtl/bilinear_half_texture_sampler.sv */
// ----------------------------------------------------------------------------
// bilinear_half_texture_sampler
// Bilinear sampler over half-float height profiles held in four parity banks.
// Throughput: one transaction per cycle unless the result stream stalls;
// reads of all four neighbors in parallel from the four banks; a write
// occupies one slot and gives no result.
// Reset clears the ready mask, the queue and all pipeline valid bits; texel
// memory is not cleared and reads back undefined until written.
// ----------------------------------------------------------------------------
module bilinear_half_texture_sampler #(
  parameter int RES_U    = 256,
  parameter int RES_V    = 256,
  parameter int PROFILES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,   // ready_mask
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // profile[1:0], texel_u[9:2], texel_v[17:10], texel_half[33:18],
  // downstream[49:34], lateral[66:50], zero[71:67]
  input  logic [71:0] in_tdata,
  input  logic [0:0]  in_tuser,    // command
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // sample_value
  output logic [0:0]  out_tuser    // sample_valid
);

  localparam int PW = (PROFILES > 1) ? $clog2(PROFILES) : 1;
  localparam int IW = PW + $clog2(RES_U) + $clog2(RES_V) + 49;

  logic          q_full;
  logic          q_not_empty;
  logic          q_pop;
  logic          push;
  logic [IW-1:0] item;
  logic [IW-1:0] head;
  logic signed [15:0] value;
  logic          flag;

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  bhts_front #(
    .RES_U    (RES_U),
    .RES_V    (RES_V),
    .PROFILES (PROFILES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .command    (in_tuser[0]),
    .profile    (in_tdata[1:0]),
    .texel_u    (in_tdata[9:2]),
    .texel_v    (in_tdata[17:10]),
    .texel_half (in_tdata[33:18]),
    .downstream (in_tdata[49:34]),
    .lateral    ($signed(in_tdata[66:50])),
    .item       (item)
  );

  bhts_fifo #(
    .WIDTH (IW),
    .DEPTH (bhts_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head)
  );

  bhts_back #(
    .RES_U    (RES_U),
    .RES_V    (RES_V),
    .PROFILES (PROFILES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_data    (head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (value),
    .out_flag  (flag)
  );

  assign out_tdata    = value;
  assign out_tuser[0] = flag;

endmodule

/* rtl/bhts_ram.sv */
// ----------------------------------------------------------------------------
// bhts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bhts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/bhts_fifo.sv */
// ----------------------------------------------------------------------------
// bhts_fifo
// Short register queue between front end and back end.
// ----------------------------------------------------------------------------
module bhts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = (AW+1)'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = (AW+1)'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign full      = (count_r == (AW+1)'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

endmodule

/* rtl/bhts_front.sv */
// ----------------------------------------------------------------------------
// bhts_front
// Holds the ready mask, classifies each transaction and scales sample
// coordinates to texel space.
// ----------------------------------------------------------------------------
module bhts_front #(
  parameter int RES_U    = 256,
  parameter int RES_V    = 256,
  parameter int PROFILES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata,
  input  logic               command,
  input  logic [1:0]         profile,
  input  logic [7:0]         texel_u,
  input  logic [7:0]         texel_v,
  input  logic [15:0]        texel_half,
  input  logic [15:0]        downstream,
  input  logic signed [16:0] lateral,
  output logic [((PROFILES > 1) ? $clog2(PROFILES) : 1) + $clog2(RES_U) + $clog2(RES_V)
                + 49 - 1:0]  item
);

  localparam int PW  = (PROFILES > 1) ? $clog2(PROFILES) : 1;
  localparam int UW  = $clog2(RES_U);
  localparam int VW  = $clog2(RES_V);
  localparam int UFW = 16 + UW;
  localparam int VFW = 17 + VW;

  typedef struct packed {
    bhts_pkg::kind_t kind;
    logic [PW-1:0]   prof;
    logic [UW-1:0]   ui;
    logic [VW-1:0]   vi;
    logic [14:0]     fu;
    logic [15:0]     fv;
    logic [15:0]     half;
  } item_t;

  logic [3:0]     ready_mask_r;
  logic [16:0]    lat_biased;
  logic [UFW-1:0] ufix;
  logic [VFW-1:0] vfix;
  logic           prof_ok;
  logic           write_ok;
  logic           sample_ok;
  item_t          it;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_mask_r <= '0;
    end else if (cfg_we) begin
      ready_mask_r <= cfg_wdata;
    end
  end

  always_comb begin
    lat_biased = 17'(lateral) + 17'(bhts_pkg::Q15_ONE);
    ufix       = UFW'(downstream) * UFW'(RES_U - 1);
    vfix       = VFW'(lat_biased) * VFW'(RES_V - 1);
    prof_ok    = (32'(profile) < PROFILES);
    write_ok   = prof_ok && (32'(texel_u) < RES_U) && (32'(texel_v) < RES_V);
    sample_ok  = prof_ok && ready_mask_r[profile]
                 && ({1'b0, downstream} <= bhts_pkg::Q15_ONE)
                 && (lateral >= -17'sd32768) && (lateral <= 17'sd32768);

    it.prof = PW'(profile);
    it.fu   = ufix[14:0];
    it.fv   = vfix[15:0];
    it.half = texel_half;
    if (command == bhts_pkg::CMD_WRITE) begin
      it.kind = write_ok ? bhts_pkg::KIND_WRITE : bhts_pkg::KIND_DROP;
      it.ui   = UW'(texel_u);
      it.vi   = VW'(texel_v);
    end else begin
      it.kind = sample_ok ? bhts_pkg::KIND_SAMPLE : bhts_pkg::KIND_ZERO;
      it.ui   = ufix[UW+14:15];
      it.vi   = vfix[VW+15:16];
    end
  end

  assign item = it;

endmodule

/* rtl/bhts_back.sv */
// ----------------------------------------------------------------------------
// bhts_back
// Banked texel store, texel decode and bilinear blend pipeline.
// ----------------------------------------------------------------------------
module bhts_back #(
  parameter int RES_U    = 256,
  parameter int RES_V    = 256,
  parameter int PROFILES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  logic [((PROFILES > 1) ? $clog2(PROFILES) : 1) + $clog2(RES_U) + $clog2(RES_V)
                + 49 - 1:0]  q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_value,
  output logic               out_flag
);

  localparam int PW  = (PROFILES > 1) ? $clog2(PROFILES) : 1;
  localparam int UW  = $clog2(RES_U);
  localparam int VW  = $clog2(RES_V);
  localparam int UHW = ($clog2((RES_U + 1) / 2) > 0) ? $clog2((RES_U + 1) / 2) : 1;
  localparam int VHW = ($clog2((RES_V + 1) / 2) > 0) ? $clog2((RES_V + 1) / 2) : 1;
  localparam int AW  = PW + UHW + VHW;

  typedef struct packed {
    bhts_pkg::kind_t kind;
    logic [PW-1:0]   prof;
    logic [UW-1:0]   ui;
    logic [VW-1:0]   vi;
    logic [14:0]     fu;
    logic [15:0]     fv;
    logic [15:0]     half;
  } item_t;

  function automatic logic signed [15:0] half_to_q15(input logic [15:0] h);
    logic [4:0]         e;
    logic [4:0]         ex;
    logic [10:0]        sig;
    logic [3:0]         sh;
    logic [31:0]        mag;
    logic signed [15:0] r;
    e   = h[14:10];
    sig = (e == 5'd0) ? {1'b0, h[9:0]} : {1'b1, h[9:0]};
    ex  = (e == 5'd0) ? 5'd1 : e;
    sh  = '0;
    if (ex >= 5'd10) begin
      mag = 32'(sig) << (ex - 5'd10);
    end else begin
      sh  = 4'(5'd10 - ex);
      mag = (32'(sig) + (32'd1 << (sh - 4'd1))) >> sh;
    end
    if (e == 5'd31) begin
      r = (h[9:0] != 10'd0) ? 16'h0000 : (h[15] ? 16'h8000 : 16'h7fff);
    end else if (h[15]) begin
      r = (mag > 32'd32768) ? 16'h8000 : 16'(32'd0 - mag);
    end else begin
      r = (mag > 32'd32767) ? 16'h7fff : mag[15:0];
    end
    return r;
  endfunction

  logic en;

  // stage 1: queued transaction, memory access
  logic  s1_valid_r;
  item_t s1_r;
  item_t head;
  logic [UHW-1:0] uh_e, uh_o;
  logic [VHW-1:0] vh_e, vh_o;
  logic           s1_write;

  // stage 2: memory data
  logic            s2_valid_r;
  bhts_pkg::kind_t s2_kind_r;
  logic            s2_up_r, s2_vp_r, s2_ut_r, s2_vt_r;
  logic [14:0]     s2_fu_r;
  logic [15:0]     s2_fv_r;
  logic [15:0]     ram_q [4];
  logic [1:0]      sel00, sel01, sel10, sel11;

  // stage 3: decoded texels and weights
  logic               s3_valid_r;
  bhts_pkg::kind_t    s3_kind_r;
  logic signed [15:0] t00_r, t01_r, t10_r, t11_r;
  logic [15:0]        wu0_r, wu1_r;
  logic [16:0]        s3_wv0_r, s3_wv1_r;

  // stage 4: partial products along u
  logic               s4_valid_r;
  bhts_pkg::kind_t    s4_kind_r;
  logic signed [31:0] p00_r, p01_r, p10_r, p11_r;
  logic [16:0]        s4_wv0_r, s4_wv1_r;

  // stage 5: full products
  logic               s5_valid_r;
  bhts_pkg::kind_t    s5_kind_r;
  logic signed [47:0] m00_r, m01_r, m10_r, m11_r;

  // stage 6: pair sums
  logic               s6_valid_r;
  bhts_pkg::kind_t    s6_kind_r;
  logic signed [48:0] sa_r, sb_r;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] out_value_r;
  logic               out_flag_r;
  logic signed [49:0] acc;
  logic signed [18:0] rnd;
  logic signed [15:0] sat;

  assign en    = !out_valid_r || out_ready;
  assign q_pop = en && q_valid;
  assign head  = q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= q_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= s4_valid_r;
      s6_valid_r  <= s5_valid_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---- stage 1: bank addressing ----
  // banks split by parity of u and v; the high neighbor sits in the other bank
  always_comb begin
    uh_e     = s1_r.ui[0] ? UHW'((s1_r.ui >> 1) + 1'b1) : UHW'(s1_r.ui >> 1);
    uh_o     = UHW'(s1_r.ui >> 1);
    vh_e     = s1_r.vi[0] ? VHW'((s1_r.vi >> 1) + 1'b1) : VHW'(s1_r.vi >> 1);
    vh_o     = VHW'(s1_r.vi >> 1);
    s1_write = en && s1_valid_r && (s1_r.kind == bhts_pkg::KIND_WRITE);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_r <= head;
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic PU = 1'((b >> 1) & 1);
    localparam logic PV = 1'(b & 1);
    logic [AW-1:0] addr;
    logic          we;
    assign addr = {s1_r.prof, (PU ? uh_o : uh_e), (PV ? vh_o : vh_e)};
    assign we   = s1_write && (s1_r.ui[0] == PU) && (s1_r.vi[0] == PV);
    bhts_ram #(
      .WIDTH (16),
      .DEPTH (1 << AW)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (addr),
      .wdata (s1_r.half),
      .re    (en),
      .raddr (addr),
      .rdata (ram_q[b])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_kind_r <= s1_r.kind;
      s2_up_r   <= s1_r.ui[0];
      s2_vp_r   <= s1_r.vi[0];
      s2_ut_r   <= (s1_r.ui == UW'(RES_U - 1));
      s2_vt_r   <= (s1_r.vi == VW'(RES_V - 1));
      s2_fu_r   <= s1_r.fu;
      s2_fv_r   <= s1_r.fv;
    end
  end

  // ---- stage 2: corner select and decode ----
  // at the far edge the high neighbor is the low one
  always_comb begin
    sel00 = {s2_up_r, s2_vp_r};
    sel01 = {s2_up_r, (s2_vt_r ? s2_vp_r : ~s2_vp_r)};
    sel10 = {(s2_ut_r ? s2_up_r : ~s2_up_r), s2_vp_r};
    sel11 = {(s2_ut_r ? s2_up_r : ~s2_up_r), (s2_vt_r ? s2_vp_r : ~s2_vp_r)};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_kind_r <= s2_kind_r;
      t00_r     <= half_to_q15(ram_q[sel00]);
      t01_r     <= half_to_q15(ram_q[sel01]);
      t10_r     <= half_to_q15(ram_q[sel10]);
      t11_r     <= half_to_q15(ram_q[sel11]);
      wu0_r     <= 16'(bhts_pkg::Q15_ONE - 17'(s2_fu_r));
      wu1_r     <= {1'b0, s2_fu_r};
      s3_wv0_r  <= 17'(bhts_pkg::Q16_ONE - 18'(s2_fv_r));
      s3_wv1_r  <= {1'b0, s2_fv_r};
    end
  end

  // ---- stages 3 to 6: weighting and sum ----
  always_ff @(posedge clk) begin
    if (en) begin
      s4_kind_r <= s3_kind_r;
      p00_r     <= t00_r * $signed({1'b0, wu0_r});
      p01_r     <= t01_r * $signed({1'b0, wu0_r});
      p10_r     <= t10_r * $signed({1'b0, wu1_r});
      p11_r     <= t11_r * $signed({1'b0, wu1_r});
      s4_wv0_r  <= s3_wv0_r;
      s4_wv1_r  <= s3_wv1_r;

      s5_kind_r <= s4_kind_r;
      m00_r     <= p00_r * $signed({1'b0, s4_wv0_r});
      m01_r     <= p01_r * $signed({1'b0, s4_wv1_r});
      m10_r     <= p10_r * $signed({1'b0, s4_wv0_r});
      m11_r     <= p11_r * $signed({1'b0, s4_wv1_r});

      s6_kind_r <= s5_kind_r;
      sa_r      <= 49'(m00_r) + 49'(m01_r);
      sb_r      <= 49'(m10_r) + 49'(m11_r);
    end
  end

  // ---- output: round half up, saturate; a rejected sample gives zero ----
  always_comb begin
    acc = 50'(sa_r) + 50'(sb_r) + 50'sd1073741824;
    rnd = acc[49:31];
    if (rnd > 19'sd32767) begin
      sat = 16'sh7fff;
    end else if (rnd < -19'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = rnd[15:0];
    end
    out_valid_nxt = s6_valid_r && ((s6_kind_r == bhts_pkg::KIND_SAMPLE)
                                || (s6_kind_r == bhts_pkg::KIND_ZERO));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r <= (s6_kind_r == bhts_pkg::KIND_SAMPLE) ? sat : 16'sh0000;
      out_flag_r  <= (s6_kind_r == bhts_pkg::KIND_SAMPLE);
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_flag  = out_flag_r;

endmodule
